/* rtl/gpc_pkg.sv */
// shared types and constants for the genotype pair correlation block
package gpc_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int GENO_W      = 3;
	localparam int COUNT_W     = 17;
	localparam int SUM_W       = 18;
	localparam int SQ_W        = 19;
	localparam int COEF_W      = 18;
	localparam int OPND_W      = 36;
	localparam int PROD_W      = 2 * OPND_W;
	localparam int UNIT_W      = PROD_W + 2;
	localparam int QUO_W       = 2 * FRAC_BITS + 1;
	localparam int ROOT_W      = QUO_W + 1;
	localparam int CNT_W       = 7;
	localparam int OP_W        = 3;
	localparam int IN_DATA_W   = 8;
	localparam int OUT_DATA_W  = 40;

	localparam logic [CNT_W-1:0] MUL_LAST   = CNT_W'(OPND_W - 1);
	localparam logic [CNT_W-1:0] DIV_LAST_R = CNT_W'(PROD_W + FRAC_BITS - 1);
	localparam logic [CNT_W-1:0] DIV_LAST_P = CNT_W'(PROD_W + 2 * FRAC_BITS - 1);

	// product schedule of the finishing sequence
	localparam logic [OP_W-1:0] OP_N_SAA  = 3'd0;
	localparam logic [OP_W-1:0] OP_SA_SA  = 3'd1;
	localparam logic [OP_W-1:0] OP_N_SBB  = 3'd2;
	localparam logic [OP_W-1:0] OP_SB_SB  = 3'd3;
	localparam logic [OP_W-1:0] OP_N_SAB  = 3'd4;
	localparam logic [OP_W-1:0] OP_SA_SB  = 3'd5;
	localparam logic [OP_W-1:0] OP_MAG_SQ = 3'd6;
	localparam logic [OP_W-1:0] OP_VA_VB  = 3'd7;

	localparam logic METHOD_R2 = 1'b0;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_LOAD = 7'b0000010,
		S_MUL  = 7'b0000100,
		S_ABS  = 7'b0001000,
		S_DIV  = 7'b0010000,
		S_SQRT = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

endpackage

/* rtl/genotype_pair_correlation.sv */
// genotype pair correlation: accumulation of sums and iterative r squared / pearson r
//
// channel   dir  handshake               payload
// s_axis    in   s_tvalid / s_tready     s_tdata {genotype_b, genotype_a}, s_tlast
// m_axis    out  m_tvalid / m_tready     m_tdata {pair_count, coefficient}, m_tuser degenerate
// cfg       in   cfg_valid / cfg_ready   cfg_data method
//
// items without tlast are taken one per cycle. an item with tlast starts the finishing
// sequence on one shared 74-bit add/subtract unit: eight shift-add products (a degenerate
// pair stops after the sixth and goes straight to the result), a sign step, 88 (r squared)
// or 104 (pearson) restoring divide steps and 17 square root steps for pearson, up to the
// loaded result register; no input is taken meanwhile.
// the result waits in an output register; the next run is taken once it is loaded.
// reset clears the sums, the method register and the handshake state.
module genotype_pair_correlation
	import gpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [2:0] genotype_a, [5:3] genotype_b
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [17:0] coefficient, [34:18] pair_count
	output logic                  m_tuser,   // [0] degenerate
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_data
);

	state_t              state_q;
	logic [OP_W-1:0]     op_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                method_q;

	logic [COUNT_W-1:0]  n_q;
	logic [SUM_W-1:0]    sa_q, sb_q;
	logic [SQ_W-1:0]     saa_q, sbb_q, sab_q;

	logic [UNIT_W-1:0]   acc_q, md_q;
	logic [OPND_W-1:0]   mr_q, va_q, vb_q, mag_q;
	logic                neg_q;
	logic [PROD_W-1:0]   num_q, den_q;
	logic [PROD_W:0]     rem_q;
	logic [QUO_W-1:0]    quo_q;
	logic [ROOT_W-1:0]   x_q, res_q, bit_q;
	logic [COEF_W-1:0]   coef_q;
	logic                degen_q;

	logic                m_tvalid_q, m_tuser_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic [GENO_W-1:0]   ga, gb;
	logic                pair_ok, s_fire, out_load;
	logic [UNIT_W-1:0]   ua, ub, usum;
	logic                usub;
	logic [OPND_W-1:0]   opa, opb;
	logic [PROD_W:0]     rem_sh;
	logic [QUO_W-1:0]    quo_nxt;
	logic [ROOT_W-1:0]   res_bit, res_nxt;
	logic [CNT_W-1:0]    div_last;

	assign ga      = s_tdata[GENO_W-1:0];
	assign gb      = s_tdata[2*GENO_W-1:GENO_W];
	// codes 0..2 only, and the count stops once bit 16 is set (at 65536)
	assign pair_ok = !ga[2] && !(ga[1] && ga[0]) && !gb[2] && !(gb[1] && gb[0]) && !n_q[16];
	assign s_tready = (state_q == S_IDLE);
	assign s_fire   = s_tvalid && s_tready;
	assign out_load = (state_q == S_DONE) && (!m_tvalid_q || m_tready);
	assign cfg_ready = 1'b1;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	assign rem_sh   = {rem_q[PROD_W-1:0], num_q[PROD_W-1]};
	assign quo_nxt  = {quo_q[QUO_W-2:0], !usum[UNIT_W-1]};
	assign res_bit  = res_q + bit_q;
	assign res_nxt  = usum[UNIT_W-1] ? (res_q >> 1) : ((res_q >> 1) + bit_q);
	assign div_last = (method_q == METHOD_R2) ? DIV_LAST_R : DIV_LAST_P;

	// operands of the product scheduled next
	always_comb begin
		case (op_q)
			OP_N_SAA:  begin opa = OPND_W'(n_q);  opb = OPND_W'(saa_q); end
			OP_SA_SA:  begin opa = OPND_W'(sa_q); opb = OPND_W'(sa_q);  end
			OP_N_SBB:  begin opa = OPND_W'(n_q);  opb = OPND_W'(sbb_q); end
			OP_SB_SB:  begin opa = OPND_W'(sb_q); opb = OPND_W'(sb_q);  end
			OP_N_SAB:  begin opa = OPND_W'(n_q);  opb = OPND_W'(sab_q); end
			OP_SA_SB:  begin opa = OPND_W'(sa_q); opb = OPND_W'(sb_q);  end
			OP_MAG_SQ: begin opa = mag_q;         opb = mag_q;          end
			default:   begin opa = va_q;          opb = vb_q;           end
		endcase
	end

	// the shared add/subtract unit
	always_comb begin
		ua   = '0;
		ub   = '0;
		usub = 1'b0;
		unique case (state_q)
			S_MUL: begin
				ua   = acc_q;
				ub   = mr_q[0] ? md_q : '0;
				usub = op_q[0] && (op_q != OP_VA_VB);
			end
			S_ABS: begin
				ub   = acc_q;
				usub = 1'b1;
			end
			S_DIV: begin
				ua   = UNIT_W'(rem_sh);
				ub   = UNIT_W'(den_q);
				usub = 1'b1;
			end
			S_SQRT: begin
				ua   = UNIT_W'(x_q);
				ub   = UNIT_W'(res_bit);
				usub = 1'b1;
			end
			default: begin
				usub = 1'b0;
			end
		endcase
		usum = ua + (usub ? ~ub : ub) + UNIT_W'(usub);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			method_q   <= METHOD_R2;
			n_q        <= '0;
			sa_q       <= '0;
			sb_q       <= '0;
			saa_q      <= '0;
			sbb_q      <= '0;
			sab_q      <= '0;
			m_tvalid_q <= 1'b0;
			op_q       <= '0;
			cnt_q      <= '0;
		end else begin
			if (cfg_valid) begin
				method_q <= cfg_data;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_fire) begin
						if (pair_ok) begin
							n_q   <= n_q + 1'b1;
							sa_q  <= sa_q + SUM_W'(ga);
							sb_q  <= sb_q + SUM_W'(gb);
							saa_q <= saa_q + SQ_W'(ga[1:0]) * SQ_W'(ga[1:0]);
							sbb_q <= sbb_q + SQ_W'(gb[1:0]) * SQ_W'(gb[1:0]);
							sab_q <= sab_q + SQ_W'(ga[1:0]) * SQ_W'(gb[1:0]);
						end
						if (s_tlast) begin
							op_q    <= OP_N_SAA;
							state_q <= S_LOAD;
						end
					end
				end
				S_LOAD: begin
					md_q  <= UNIT_W'(opa);
					mr_q  <= opb;
					cnt_q <= '0;
					// odd products subtract from the running sum, va*vb stands alone
					if (!op_q[0] || op_q == OP_VA_VB) begin
						acc_q <= '0;
					end
					state_q <= S_MUL;
				end
				S_MUL: begin
					acc_q <= usum;
					md_q  <= md_q << 1;
					mr_q  <= mr_q >> 1;
					if (cnt_q != MUL_LAST) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						op_q <= op_q + 1'b1;
						case (op_q)
							OP_SA_SA: begin
								va_q    <= usum[OPND_W-1:0];
								state_q <= S_LOAD;
							end
							OP_SB_SB: begin
								vb_q    <= usum[OPND_W-1:0];
								state_q <= S_LOAD;
							end
							OP_SA_SB: state_q <= S_ABS;
							OP_MAG_SQ: begin
								num_q   <= usum[PROD_W-1:0];
								state_q <= S_LOAD;
							end
							OP_VA_VB: begin
								den_q   <= usum[PROD_W-1:0];
								rem_q   <= '0;
								quo_q   <= '0;
								cnt_q   <= '0;
								state_q <= S_DIV;
							end
							default: state_q <= S_LOAD;
						endcase
					end
				end
				S_ABS: begin
					neg_q <= acc_q[UNIT_W-1];
					mag_q <= acc_q[UNIT_W-1] ? usum[OPND_W-1:0] : acc_q[OPND_W-1:0];
					if (n_q == '0 || va_q == '0 || vb_q == '0) begin
						degen_q <= 1'b1;
						coef_q  <= '0;
						state_q <= S_DONE;
					end else begin
						degen_q <= 1'b0;
						state_q <= S_LOAD;
					end
				end
				S_DIV: begin
					num_q <= num_q << 1;
					quo_q <= quo_nxt;
					rem_q <= usum[UNIT_W-1] ? rem_sh : usum[PROD_W:0];
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == div_last) begin
						if (method_q == METHOD_R2) begin
							coef_q  <= quo_nxt[COEF_W-1:0];
							state_q <= S_DONE;
						end else begin
							x_q     <= ROOT_W'(quo_nxt);
							res_q   <= '0;
							bit_q   <= ROOT_W'(1) << (2 * FRAC_BITS);
							state_q <= S_SQRT;
						end
					end
				end
				S_SQRT: begin
					if (!usum[UNIT_W-1]) begin
						x_q <= usum[ROOT_W-1:0];
					end
					res_q <= res_nxt;
					bit_q <= bit_q >> 2;
					if (bit_q == ROOT_W'(1)) begin
						coef_q  <= neg_q ? (COEF_W'(0) - res_nxt[COEF_W-1:0])
						                 : res_nxt[COEF_W-1:0];
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						m_tdata_q  <= OUT_DATA_W'({n_q, coef_q});
						m_tuser_q  <= degen_q;
						n_q        <= '0;
						sa_q       <= '0;
						sb_q       <= '0;
						saa_q      <= '0;
						sbb_q      <= '0;
						sab_q      <= '0;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
